// ===== hdl/wti_pkg.sv =====
// Shared types and constants for the waypoint trajectory interpolator.
package wti_pkg;

   localparam int MAX_POINTS = 16;
   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = 5;
   localparam int POS_W = 24;
   localparam int TIME_W = 32;
   localparam int PROD_W = 25 + TIME_W;

   localparam logic [1:0] REQ_WRITE  = 2'd0;
   localparam logic [1:0] REQ_QUERY  = 2'd1;
   localparam logic [1:0] REQ_REWIND = 2'd2;

   typedef struct packed {
      logic [1:0]               req_type;
      logic [3:0]               entry_index;
      logic signed [POS_W-1:0]  way_x;
      logic signed [POS_W-1:0]  way_y;
      logic signed [POS_W-1:0]  way_z;
      logic [TIME_W-1:0]        seg_duration;
      logic [TIME_W-1:0]        target_time;
   } req_type_type;

   typedef struct packed {
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [POS_W-1:0]  pos_z;
      logic [3:0]               segment;
      logic                     at_end;
      logic                     zero_span;
   } rsp_type_type;

   // controller -> datapath
   typedef struct packed {
      logic       load;       // capture request, do write or rewind
      logic       check;      // rewind if target before start or segment at or past count
      logic       read_seg;   // read current segment entry
      logic       step;       // advance segment if target past end
      logic       read_next;  // read next entry
      logic       div_start;
      logic       div_step;
      logic       finish;     // build result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_query;
      logic adv_ok;     // may advance
      logic last;       // on final segment
      logic zero;       // duration zero
      logic div_done;
   } sts_type;

endpackage

// ===== hdl/wti_ctrl.sv =====
// Sequencer for the waypoint walk and the serial divide.
module wti_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  wti_pkg::sts_type   sts,
   output wti_pkg::cmd_type   cmd
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_WALK = 3'd3;
   localparam logic [2:0] S_NEXT = 3'd4;
   localparam logic [2:0] S_DIV = 3'd5;
   localparam logic [2:0] S_FIN = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       out_ff, out_in;

   assign req_ready = (state_ff == S_IDLE) && !out_ff;
   assign rsp_valid = out_ff;

   always_comb begin
      state_in = state_ff;
      out_in = out_ff && !rsp_ready;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.is_query) begin
               cmd.check = 1'b1;
               state_in = S_READ;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            cmd.read_seg = 1'b1;
            state_in = S_WALK;
         end
         S_WALK: begin
            if (sts.adv_ok) begin
               cmd.step = 1'b1;
               state_in = S_READ;
            end else if (sts.last || sts.zero) begin
               state_in = S_FIN;
            end else begin
               cmd.read_next = 1'b1;
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            cmd.div_start = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = S_FIN;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            out_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_ff <= out_in;
      end
   end
endmodule

// ===== hdl/wti_datapath.sv =====
// Waypoint table, walk registers, serial divider and result register.
module wti_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [4:0]              csr_write_data,
   input  wti_pkg::req_type_type   req_data,
   input  wti_pkg::cmd_type        cmd,
   output wti_pkg::sts_type        sts,
   output wti_pkg::rsp_type_type   rsp_data
);
   localparam int IW = wti_pkg::IDX_W;
   localparam int PW = wti_pkg::POS_W;
   localparam int TW = wti_pkg::TIME_W;
   localparam int QW = wti_pkg::PROD_W;
   localparam int AXES = 3;

   logic [3*PW+TW-1:0] mem [wti_pkg::MAX_POINTS];

   wti_pkg::req_type_type req_ff;
   logic [4:0]    count_ff;
   logic [IW:0]   cnt;
   logic [IW:0]   seg_ff;
   logic [TW-1:0] start_ff;
   logic [3*PW+TW-1:0] cur_ff;
   logic [IW-1:0] raddr;
   logic [3*PW+TW-1:0] rdata_ff;
   logic          wr_pend_ff;
   logic [TW-1:0] dur;
   logic [TW:0]   seg_end;
   logic          last;

   logic [AXES-1:0]       neg_ff;
   logic [QW-1:0]         rem_ff [AXES];
   logic [QW-1:0]         quo_ff [AXES];
   logic [QW-1:0]         dvd_ff [AXES];
   logic [6:0]            bit_ff;
   logic [TW-1:0]         el;
   wti_pkg::rsp_type_type rsp_ff;

   always_comb begin
      if (count_ff == 5'd0) cnt = (IW+1)'(1);
      else if (32'(count_ff) > wti_pkg::MAX_POINTS) cnt = (IW+1)'(wti_pkg::MAX_POINTS);
      else cnt = (IW+1)'(count_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= 5'd1;
      else if (csr_write_enable) count_ff <= csr_write_data;
   end

   always_ff @(posedge clock) begin
      if (reset) wr_pend_ff <= 1'b0;
      else wr_pend_ff <= cmd.load && req_data.req_type == wti_pkg::REQ_WRITE;
   end

   // memory: one write, one registered read
   assign raddr = cmd.read_next ? seg_ff[IW-1:0] + IW'(1) : seg_ff[IW-1:0];
   always_ff @(posedge clock) begin
      if (wr_pend_ff)
         mem[req_ff.entry_index[IW-1:0]] <= {req_ff.way_x, req_ff.way_y,
                                             req_ff.way_z, req_ff.seg_duration};
      rdata_ff <= mem[raddr];
   end

   assign dur = rdata_ff[TW-1:0];
   assign seg_end = {1'b0, start_ff} + {1'b0, dur};
   assign last = (seg_ff + (IW+1)'(1)) >= cnt;

   always_comb begin
      sts.is_query = req_ff.req_type == wti_pkg::REQ_QUERY;
      sts.last = last;
      sts.adv_ok = !last && ({1'b0, req_ff.target_time} > seg_end);
      sts.zero = dur == '0;
      sts.div_done = bit_ff == 7'd0;
   end

   // clamp elapsed time to the current segment duration
   assign el = ((req_ff.target_time - start_ff) > cur_ff[TW-1:0]) ? cur_ff[TW-1:0]
             : req_ff.target_time - start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= '0;
         start_ff <= '0;
      end else if (cmd.load && req_data.req_type == wti_pkg::REQ_REWIND) begin
         seg_ff <= '0;
         start_ff <= '0;
      end else if (cmd.check) begin
         if (req_ff.target_time < start_ff || seg_ff >= cnt) begin
            seg_ff <= '0;
            start_ff <= '0;
         end
      end else if (cmd.step) begin
         seg_ff <= seg_ff + (IW+1)'(1);
         start_ff <= seg_end[TW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
      if (cmd.read_next) cur_ff <= rdata_ff;
   end

   // restoring divider, one quotient bit per cycle for all axes
   always_ff @(posedge clock) begin
      logic signed [PW:0] d;
      logic [PW-1:0] mag;
      logic [PW+TW-1:0] prod;
      logic [QW:0] r2;
      if (cmd.div_start) begin
         for (int a = 0; a < AXES; a++) begin
            d = $signed(rdata_ff[TW+PW*a +: PW]) - $signed(cur_ff[TW+PW*a +: PW]);
            neg_ff[a] <= d[PW];
            mag = d[PW] ? PW'(-d) : PW'(d);
            prod = mag * el;
            dvd_ff[a] <= QW'(prod) + QW'(cur_ff[TW-1:0] >> 1);
            rem_ff[a] <= '0;
            quo_ff[a] <= '0;
         end
         bit_ff <= 7'(QW);
      end else if (cmd.div_step && bit_ff != 7'd0) begin
         for (int a = 0; a < AXES; a++) begin
            r2 = {rem_ff[a], dvd_ff[a][QW-1]};
            dvd_ff[a] <= dvd_ff[a] << 1;
            if (r2 >= (QW+1)'(cur_ff[TW-1:0])) begin
               rem_ff[a] <= QW'(r2 - (QW+1)'(cur_ff[TW-1:0]));
               quo_ff[a] <= {quo_ff[a][QW-2:0], 1'b1};
            end else begin
               rem_ff[a] <= QW'(r2);
               quo_ff[a] <= {quo_ff[a][QW-2:0], 1'b0};
            end
         end
         bit_ff <= bit_ff - 7'd1;
      end
   end

   function automatic logic [PW-1:0] sat(input logic signed [QW+1:0] v);
      if (v > (QW+2)'(signed'(2**(PW-1)-1))) return {1'b0, {(PW-1){1'b1}}};
      if (v < -(QW+2)'(signed'(2**(PW-1)))) return {1'b1, {(PW-1){1'b0}}};
      return v[PW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      logic signed [QW+1:0] base, q, v;
      if (cmd.finish) begin
         for (int a = 0; a < AXES; a++) begin
            if (last || sts.zero) begin
               v = (QW+2)'($signed(rdata_ff[TW+PW*a +: PW]));
            end else begin
               base = (QW+2)'($signed(cur_ff[TW+PW*a +: PW]));
               q = $signed({2'b00, quo_ff[a]});
               v = neg_ff[a] ? base - q : base + q;
            end
            if (a == 2) rsp_ff.pos_x <= sat(v);
            if (a == 1) rsp_ff.pos_y <= sat(v);
            if (a == 0) rsp_ff.pos_z <= sat(v);
         end
         rsp_ff.segment <= 4'(seg_ff);
         rsp_ff.at_end <= last;
         rsp_ff.zero_span <= !last && sts.zero;
      end
   end

   assign rsp_data = rsp_ff;
endmodule

// ===== hdl/waypoint_trajectory_interpolator_core.sv =====
// Top level of the waypoint trajectory interpolator.
// Writes, rewinds and unused requests pass through the CHECK state and back to
// IDLE before the next accept. A query alternates the READ and WALK states for
// each segment it walks, then runs a restoring divide with one divider per axis
// for the three axes; the walk advances at most fifteen segments. A query that
// lands on the last waypoint or a zero span skips the divide.
// One transaction is in flight; the next is taken once the result is held in
// the output register and taken.
module waypoint_trajectory_interpolator_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  wti_pkg::req_type_type   req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output wti_pkg::rsp_type_type   rsp_data,
   input  logic                    csr_write_enable,
   input  logic [4:0]              csr_write_data
);
   wti_pkg::cmd_type cmd;
   wti_pkg::sts_type sts;

   wti_ctrl u_ctrl (.clock, .reset, .req_valid, .req_ready, .rsp_valid,
                    .rsp_ready, .sts, .cmd);
   wti_datapath u_dp (.clock, .reset, .csr_write_enable, .csr_write_data,
                      .req_data, .cmd, .sts, .rsp_data);
endmodule

// ===== hdl/wti_checker.sv =====
// Port-level checks for the interpolator core.
module wti_sva (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input wti_pkg::rsp_type_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)) else $error("rsp dropped");
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("accept while result pending");
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.at_end && rsp_data.zero_span)) else $error("flags");
   a_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("back to back accept");
endmodule

bind waypoint_trajectory_interpolator_core wti_sva u_chk (.clock, .reset, .req_valid,
   .req_ready, .rsp_valid, .rsp_ready, .rsp_data);
